### src/efas_pkg.sv
// Shared types and constants for the extended-precision adder/subtractor.
// No dependencies; imported by efas_normalize and extended_float_add_sub.
`timescale 1ns / 1ps

package efas_pkg;

   localparam int MantWidth     = 64;
   localparam int MantPortWidth = 64;
   localparam int ExpWidth      = 15;
   localparam logic [ExpWidth-1:0] ExpMax = {ExpWidth{1'b1}};

   localparam int DiffWidth    = ExpWidth + 1;
   localparam int WideWidth    = 2 * MantWidth;
   localparam int ShiftWidth   = $clog2(MantWidth + 1);
   localparam int PosWidth     = $clog2(WideWidth);
   localparam int ExpCalcWidth = ExpWidth + 2;

   // leading-one search runs in groups: encode inside groups, then pick a group
   localparam int GroupWidth = 8;
   localparam int GroupBits  = $clog2(GroupWidth);
   localparam int NumGroups  = (WideWidth + GroupWidth - 1) / GroupWidth;
   localparam int PadWidth   = NumGroups * GroupWidth;

   typedef struct packed {
      logic                 valid;
      logic                 far;
      logic                 eff_sub;
      logic                 sign;
      logic [ExpWidth-1:0]  exp;
      logic [WideWidth-1:0] v;
   } efas_sum_type;

   typedef struct packed {
      logic                 valid;
      logic                 sign;
      logic [ExpWidth-1:0]  exponent;
      logic [MantWidth-1:0] mantissa;
      logic                 overflow;
   } efas_result_type;

endpackage

### src/extended_float_add_sub.sv
// Top level of the extended-precision adder/subtractor: operand swap, alignment
// and add/subtract stages. Depends on efas_pkg and efas_normalize.
`timescale 1ns / 1ps
// Result: rsp_valid is high for one cycle once an accepted start has passed all
//   register stages.
// Throughput: one operation per cycle while busy is low, six register stages, no stalls; the receiver
//   cannot hold results off, so nothing ever waits.
// Reset: synchronous, active high; clears all stage valid bits. busy is a registered copy
//   of reset, so it is also high in the cycle after reset drops.

module extended_float_add_sub
   import efas_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_a_sign,
   input  logic [ExpWidth-1:0]      req_a_exponent,
   input  logic [MantPortWidth-1:0] req_a_mantissa,
   input  logic                     req_b_sign,
   input  logic [ExpWidth-1:0]      req_b_exponent,
   input  logic [MantPortWidth-1:0] req_b_mantissa,
   output logic                     rsp_valid,
   output logic                     rsp_sum_sign,
   output logic [ExpWidth-1:0]      rsp_sum_exponent,
   output logic [MantPortWidth-1:0] rsp_sum_mantissa,
   output logic                     rsp_exponent_overflow
);

   logic busy_ff, busy_in;
   logic accept;

   assign busy_in = reset;
   assign accept  = start & ~busy_ff;
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 1: exponent difference and swap. The operand with the larger exponent
   // becomes "big" and is the one shifted left by the difference. For far
   // exponents the shift is forced to zero so the big operand rides the whole
   // pipe unchanged, and the exponent slot carries its exponent instead of the
   // smaller one.
   // ---------------------------------------------------------------------------
   logic [MantWidth-1:0]  ma, mb;
   logic [DiffWidth-1:0]  diff, absdiff;
   logic                  swap, far;

   logic                  s1_valid_ff, s1_far_ff, s1_far_in;
   logic                  s1_sbig_ff, s1_sbig_in, s1_ssmall_ff, s1_ssmall_in;
   logic [ExpWidth-1:0]   s1_exp_ff, s1_exp_in;
   logic [ShiftWidth-1:0] s1_shift_ff, s1_shift_in;
   logic [MantWidth-1:0]  s1_big_ff, s1_big_in, s1_small_ff, s1_small_in;

   always_comb begin
      ma      = req_a_mantissa[MantWidth-1:0];
      mb      = req_b_mantissa[MantWidth-1:0];
      diff    = DiffWidth'(req_a_exponent) - DiffWidth'(req_b_exponent);
      swap    = diff[DiffWidth-1];
      absdiff = swap ? (~diff + DiffWidth'(1)) : diff;
      far     = absdiff > DiffWidth'(MantWidth);

      s1_far_in    = far;
      s1_sbig_in   = swap ? req_b_sign : req_a_sign;
      s1_ssmall_in = swap ? req_a_sign : req_b_sign;
      s1_big_in    = swap ? mb : ma;
      s1_small_in  = swap ? ma : mb;
      s1_shift_in  = far ? '0 : absdiff[ShiftWidth-1:0];
      if (far) begin
         s1_exp_in = swap ? req_b_exponent : req_a_exponent;
      end else begin
         s1_exp_in = swap ? req_a_exponent : req_b_exponent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_far_ff    <= s1_far_in;
      s1_sbig_ff   <= s1_sbig_in;
      s1_ssmall_ff <= s1_ssmall_in;
      s1_exp_ff    <= s1_exp_in;
      s1_shift_ff  <= s1_shift_in;
      s1_big_ff    <= s1_big_in;
      s1_small_ff  <= s1_small_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 2: align. Big mantissa shifted left into the double-width window.
   // ---------------------------------------------------------------------------
   logic                 s2_valid_ff, s2_far_ff, s2_sbig_ff, s2_ssmall_ff;
   logic [ExpWidth-1:0]  s2_exp_ff;
   logic [WideWidth-1:0] s2_big_ff, s2_big_in;
   logic [MantWidth-1:0] s2_small_ff;

   assign s2_big_in = WideWidth'(s1_big_ff) << s1_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_far_ff    <= s1_far_ff;
      s2_sbig_ff   <= s1_sbig_ff;
      s2_ssmall_ff <= s1_ssmall_ff;
      s2_exp_ff    <= s1_exp_ff;
      s2_big_ff    <= s2_big_in;
      s2_small_ff  <= s1_small_ff;
   end

   // ---------------------------------------------------------------------------
   // Stage 3: add or subtract. Both differences are formed in parallel and the
   // borrow of big - small picks the non-negative one, which also settles the
   // sign. The window never carries out: a 64-bit value shifted by at most 64
   // plus a 64-bit value fits in 128 bits.
   // ---------------------------------------------------------------------------
   logic                 eff_sub, big_lt;
   logic [WideWidth:0]   d_big;
   logic [WideWidth-1:0] small_w, d_small, add_w;
   efas_sum_type         s3_ff, s3_in;

   always_comb begin
      small_w = WideWidth'(s2_small_ff);
      eff_sub = s2_sbig_ff ^ s2_ssmall_ff;
      d_big   = {1'b0, s2_big_ff} - {1'b0, small_w};
      big_lt  = d_big[WideWidth];
      d_small = small_w - s2_big_ff;
      add_w   = s2_big_ff + small_w;

      s3_in.valid   = s2_valid_ff;
      s3_in.far     = s2_far_ff;
      s3_in.eff_sub = eff_sub;
      s3_in.exp     = s2_exp_ff;
      s3_in.sign    = (eff_sub && big_lt && !s2_far_ff) ? s2_ssmall_ff : s2_sbig_ff;
      priority if (s2_far_ff) begin
         s3_in.v = s2_big_ff;
      end else if (!eff_sub) begin
         s3_in.v = add_w;
      end else if (big_lt) begin
         s3_in.v = d_small;
      end else begin
         s3_in.v = d_big[WideWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else begin
         s3_ff.valid <= s3_in.valid;
      end
      s3_ff.far     <= s3_in.far;
      s3_ff.eff_sub <= s3_in.eff_sub;
      s3_ff.sign    <= s3_in.sign;
      s3_ff.exp     <= s3_in.exp;
      s3_ff.v       <= s3_in.v;
   end

   // ---------------------------------------------------------------------------
   // Stages 4..6: leading one, normalize, exponent adjust and special cases.
   // ---------------------------------------------------------------------------
   efas_result_type result;

   efas_normalize u_normalize (
      .clock      (clock),
      .reset      (reset),
      .sum_in     (s3_ff),
      .result_out (result)
   );

   assign rsp_valid             = result.valid;
   assign rsp_sum_sign          = result.sign;
   assign rsp_sum_exponent      = result.exponent;
   assign rsp_sum_mantissa      = MantPortWidth'(result.mantissa);
   assign rsp_exponent_overflow = result.overflow;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("accepted transfer produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##6 !rsp_valid)
      else $error("result strobe without an accepted transfer");

   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exponent_overflow |->
         rsp_sum_exponent == ExpMax && rsp_sum_mantissa == MantPortWidth'({MantWidth{1'b1}}))
      else $error("overflow without saturated result");

endmodule

### src/efas_normalize.sv
// Leading-one search, normalization and exponent adjust: three register stages.
// Depends on efas_pkg.
`timescale 1ns / 1ps

module efas_normalize
   import efas_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  efas_sum_type    sum_in,
   output efas_result_type result_out
);

   // stage 4: per-group encode
   efas_sum_type                   s4_ff;
   logic [NumGroups-1:0]           s4_nz_ff, s4_nz_in;
   logic [NumGroups-1:0][GroupBits-1:0] s4_pos_ff, s4_pos_in;
   logic [PadWidth-1:0]            padded;

   always_comb begin
      padded = PadWidth'(sum_in.v);
      for (int g = 0; g < NumGroups; g++) begin
         s4_nz_in[g]  = |padded[g*GroupWidth +: GroupWidth];
         s4_pos_in[g] = '0;
         for (int b = 0; b < GroupWidth; b++) begin
            if (padded[g*GroupWidth + b]) begin
               s4_pos_in[g] = GroupBits'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else begin
         s4_ff.valid <= sum_in.valid;
      end
      s4_ff.far     <= sum_in.far;
      s4_ff.eff_sub <= sum_in.eff_sub;
      s4_ff.sign    <= sum_in.sign;
      s4_ff.exp     <= sum_in.exp;
      s4_ff.v       <= sum_in.v;
      s4_nz_ff      <= s4_nz_in;
      s4_pos_ff     <= s4_pos_in;
   end

   // stage 5: pick the top nonzero group
   efas_sum_type        s5_ff;
   logic [PosWidth-1:0] s5_p_ff, s5_p_in;
   logic                s5_zero_ff, s5_zero_in;

   always_comb begin
      s5_p_in    = '0;
      s5_zero_in = ~|s4_nz_ff;
      for (int g = 0; g < NumGroups; g++) begin
         if (s4_nz_ff[g]) begin
            s5_p_in = PosWidth'(g * GroupWidth + int'(s4_pos_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
      end else begin
         s5_ff.valid <= s4_ff.valid;
      end
      s5_ff.far     <= s4_ff.far;
      s5_ff.eff_sub <= s4_ff.eff_sub;
      s5_ff.sign    <= s4_ff.sign;
      s5_ff.exp     <= s4_ff.exp;
      s5_ff.v       <= s4_ff.v;
      s5_p_ff       <= s5_p_in;
      s5_zero_ff    <= s5_zero_in;
   end

   // stage 6: shift the leading one to the top, adjust the exponent
   efas_result_type          res_ff, res_in;
   logic                     far_ff;
   logic [PosWidth-1:0]      lshift;
   logic [WideWidth-1:0]     norm;
   logic signed [ExpCalcWidth-1:0] re;

   always_comb begin
      lshift = PosWidth'(WideWidth - 1) - s5_p_ff;
      norm   = s5_ff.v << lshift;
      re     = signed'(ExpCalcWidth'(s5_ff.exp)) + signed'(ExpCalcWidth'(s5_p_ff))
               - signed'(ExpCalcWidth'(MantWidth - 1));

      res_in.valid    = s5_ff.valid;
      res_in.sign     = s5_ff.sign;
      res_in.exponent = re[ExpWidth-1:0];
      res_in.mantissa = norm[WideWidth-1 -: MantWidth];
      res_in.overflow = 1'b0;
      priority if (s5_ff.far) begin
         res_in.exponent = s5_ff.exp;
         res_in.mantissa = s5_ff.v[MantWidth-1:0];
      end else if (s5_zero_ff) begin
         // exact cancellation gives +0
         res_in.sign     = s5_ff.sign & ~s5_ff.eff_sub;
         res_in.exponent = '0;
         res_in.mantissa = '0;
      end else if (re > signed'(ExpCalcWidth'(ExpMax))) begin
         res_in.exponent = ExpMax;
         res_in.mantissa = '1;
         res_in.overflow = 1'b1;
      end else if (re[ExpCalcWidth-1]) begin
         // underflow flushes to zero, sign kept
         res_in.exponent = '0;
         res_in.mantissa = '0;
      end else begin
         // exponent in range: normalized defaults stand
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.sign     <= res_in.sign;
      res_ff.exponent <= res_in.exponent;
      res_ff.mantissa <= res_in.mantissa;
      res_ff.overflow <= res_in.overflow;
      far_ff          <= s5_ff.far;
   end

   assign result_out = res_ff;

   a_lead_found: assert property (@(posedge clock) disable iff (reset)
      s5_ff.valid && !s5_zero_ff |-> s5_ff.v[s5_p_ff])
      else $error("leading-one position does not point at a set bit");

   a_zero_true: assert property (@(posedge clock) disable iff (reset)
      s5_ff.valid && s5_zero_ff |-> s5_ff.v == '0)
      else $error("zero flagged on a nonzero sum");

   a_normalized: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid && !far_ff && res_ff.mantissa != '0 |-> res_ff.mantissa[MantWidth-1])
      else $error("result mantissa not normalized");

endmodule
